// ===== hw/rtl/ckhs_pkg.sv =====
package ckhs_pkg;

    localparam int TABLE_SLOTS_DEF = 4096;
    localparam int MAX_PROBES_DEF  = 16;
    localparam int KEY_W           = 64;
    localparam int KLEN_W          = 6;
    localparam int COUNT_W         = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;
    localparam logic [KLEN_W-1:0]  KLEN_RESET = 6'd31;

    localparam logic [63:0] MUR_M = 64'hc6a4a7935bd1e995;
    localparam int          MUR_R = 47;
    // eight key bytes times m
    localparam logic [63:0] MUR_H0 = 64'(64'd8 * 64'hc6a4a7935bd1e995);

    // multiply phases of the hash unit
    typedef enum logic [2:0] {
        MUL_K1 = 3'd0,
        MUL_K2 = 3'd1,
        MUL_H1 = 3'd2,
        MUL_H2 = 3'd3
    } t_mul_sel;

    // controller to datapath
    typedef struct packed {
        logic     clr;        // clear one valid bit of the table
        logic     load;       // capture item, form canonical key
        logic     mul_step;   // advance one partial product
        logic     mul_start;  // start a 64x64 product
        t_mul_sel mul_sel;
        logic     mul_done_apply;
        logic     slot_init;  // home slot from hash
        logic     rd_issue;   // read probed slot
        logic     slot_next;  // advance probe
        logic     wr_key;     // store key at probed slot
        logic     emit;
        logic     res_found;
        logic     res_added;
        logic     res_full;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic mul_busy;
        logic slot_valid;
        logic key_match;
        logic op_insert;
    } t_sts;

    function automatic logic [63:0] rev_comp(input logic [63:0] s_in,
                                             input logic [KLEN_W-1:0] klen);
        logic [63:0] s;
        logic [5:0]  k;
        logic [6:0]  sh;
        s = ~s_in;
        s = ((s & 64'h3333333333333333) << 2)  | ((s >> 2)  & 64'h3333333333333333);
        s = ((s & 64'h0F0F0F0F0F0F0F0F) << 4)  | ((s >> 4)  & 64'h0F0F0F0F0F0F0F0F);
        s = ((s & 64'h00FF00FF00FF00FF) << 8)  | ((s >> 8)  & 64'h00FF00FF00FF00FF);
        s = ((s & 64'h0000FFFF0000FFFF) << 16) | ((s >> 16) & 64'h0000FFFF0000FFFF);
        s = ((s & 64'h00000000FFFFFFFF) << 32) | ((s >> 32) & 64'h00000000FFFFFFFF);
        if (klen == 6'd0) begin
            k = 6'd1;
        end else if (klen > 6'd32) begin
            k = 6'd32;
        end else begin
            k = klen;
        end
        sh = 7'd64 - {k, 1'b0};
        return s >> sh;
    endfunction

endpackage

// ===== hw/rtl/canonical_kmer_hash_set_top.sv =====
// sequence: an accepted item runs through four products (start, run, apply) on one
// shared 32x32 multiplier, the home slot, a table read and check per probed slot,
// emit, and the result register
// throughput: one item at a time, next item taken in the result cycle
// reset: synchronous; busy held while the valid bits are cleared,
// count cleared, kmer_length back to 31; results cannot be stalled
module canonical_kmer_hash_set_top #(
    parameter int TABLE_SLOTS = ckhs_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_PROBES  = ckhs_pkg::MAX_PROBES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cfg_we,
    input  logic [ckhs_pkg::KLEN_W-1:0]  i_cfg_wdata,
    input  logic                         i_op,
    input  logic [63:0]                  i_kmer,
    output logic                         o_result_valid,
    output logic                         o_found,
    output logic                         o_added,
    output logic                         o_table_full,
    output logic [ckhs_pkg::COUNT_W-1:0] o_distinct_count
);
    logic [ckhs_pkg::KLEN_W-1:0] r_kmer_length;
    ckhs_pkg::t_ctl ctl;
    ckhs_pkg::t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= ckhs_pkg::KLEN_RESET;
        end else if (i_cfg_we) begin
            r_kmer_length <= i_cfg_wdata;
        end
    end

    ckhs_ctrl #(.MAX_PROBES(MAX_PROBES)) u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_sts(sts), .o_ctl(ctl), .o_busy(busy)
    );

    ckhs_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
        .i_clk, .i_rst_n, .i_kmer_length(r_kmer_length), .i_op, .i_kmer,
        .i_ctl(ctl), .o_sts(sts), .o_found, .o_added, .o_table_full,
        .o_distinct_count, .o_result_valid
    );
endmodule

// ===== hw/rtl/ckhs_datapath.sv =====
module ckhs_datapath #(
    parameter int TABLE_SLOTS = ckhs_pkg::TABLE_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ckhs_pkg::KLEN_W-1:0]    i_kmer_length,
    input  logic                           i_op,
    input  logic [63:0]                    i_kmer,
    input  ckhs_pkg::t_ctl                 i_ctl,
    output ckhs_pkg::t_sts                 o_sts,
    output logic                           o_found,
    output logic                           o_added,
    output logic                           o_table_full,
    output logic [ckhs_pkg::COUNT_W-1:0]   o_distinct_count,
    output logic                           o_result_valid
);
    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    logic             r_op;
    logic [63:0]      r_key;
    logic [63:0]      r_k;
    logic [63:0]      r_h;
    logic [63:0]      r_a;
    logic [63:0]      r_b;
    logic [63:0]      r_acc;
    logic [1:0]       r_ph;
    logic             r_mbusy;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_rd_slot;
    logic [SLOT_W-1:0] r_clr_slot;
    logic             r_vld_rd;
    logic [63:0]      r_key_rd;
    logic             r_vmem [TABLE_SLOTS];
    logic [63:0]      r_mem [TABLE_SLOTS];
    logic [ckhs_pkg::COUNT_W-1:0] r_count;
    logic             r_found, r_added, r_full, r_rv;

    logic [63:0] rc;
    logic [63:0] km_x;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] pp;
    logic [63:0] n_acc;

    assign rc   = ckhs_pkg::rev_comp(i_kmer, i_kmer_length);
    assign km_x = r_k ^ (r_k >> ckhs_pkg::MUR_R);
    // one shared 32x32 multiplier, low 64 bits of the product kept
    assign mul_a = (r_ph == 2'd1) ? r_a[63:32] : r_a[31:0];
    assign mul_b = (r_ph == 2'd2) ? r_b[63:32] : r_b[31:0];
    assign prod  = {32'd0, mul_a} * {32'd0, mul_b};
    assign pp    = (r_ph == 2'd0) ? prod : {prod[31:0], 32'd0};
    assign n_acc = r_acc + pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy    <= 1'b0;
            r_ph       <= 2'd0;
            r_clr_slot <= '0;
            r_count    <= '0;
            r_rv       <= 1'b0;
        end else begin
            r_rv <= i_ctl.emit;
            if (i_ctl.clr) begin
                r_clr_slot <= r_clr_slot + SLOT_W'(1);
            end
            if (i_ctl.load) begin
                r_op  <= i_op;
                r_key <= (i_kmer > rc) ? rc : i_kmer;
            end
            if (i_ctl.mul_start) begin
                unique case (i_ctl.mul_sel)
                    ckhs_pkg::MUL_K1: r_a <= r_key;
                    ckhs_pkg::MUL_K2: r_a <= km_x;
                    ckhs_pkg::MUL_H1: r_a <= ckhs_pkg::MUR_H0 ^ r_k;
                    ckhs_pkg::MUL_H2: r_a <= r_h ^ (r_h >> ckhs_pkg::MUR_R);
                    default:          r_a <= r_key;
                endcase
                r_b     <= ckhs_pkg::MUR_M;
                r_acc   <= '0;
                r_ph    <= 2'd0;
                r_mbusy <= 1'b1;
            end else if (i_ctl.mul_step) begin
                r_acc <= n_acc;
                r_ph  <= r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    r_mbusy <= 1'b0;
                end
            end
            if (i_ctl.mul_done_apply) begin
                unique case (i_ctl.mul_sel)
                    ckhs_pkg::MUL_K1, ckhs_pkg::MUL_K2: r_k <= r_acc;
                    default:                            r_h <= r_acc;
                endcase
            end
            if (i_ctl.slot_init) begin
                r_slot <= SLOT_W'(r_h ^ (r_h >> ckhs_pkg::MUR_R));
            end else if (i_ctl.slot_next) begin
                r_slot <= r_slot + SLOT_W'(1);
            end
            if (i_ctl.rd_issue) begin
                r_rd_slot <= r_slot;
            end
            if (i_ctl.wr_key) begin
                if (r_count != ckhs_pkg::COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_ctl.emit) begin
                r_found <= i_ctl.res_found;
                r_added <= i_ctl.res_added;
                r_full  <= i_ctl.res_full;
            end
        end
    end

    // valid bits are cleared by a pass over the table after reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_issue) begin
            r_vld_rd <= r_vmem[r_slot];
            r_key_rd <= r_mem[r_slot];
        end
        if (i_ctl.clr) begin
            r_vmem[r_clr_slot] <= 1'b0;
        end else if (i_ctl.wr_key) begin
            r_vmem[r_rd_slot] <= 1'b1;
        end
        if (i_ctl.wr_key) begin
            r_mem[r_rd_slot] <= r_key;
        end
    end

    assign o_sts.clr_last   = (r_clr_slot == SLOT_W'(TABLE_SLOTS - 1));
    assign o_sts.mul_busy   = r_mbusy;
    assign o_sts.slot_valid = r_vld_rd;
    assign o_sts.key_match  = (r_key_rd == r_key);
    assign o_sts.op_insert  = r_op;

    assign o_found          = r_found;
    assign o_added          = r_added;
    assign o_table_full     = r_full;
    assign o_distinct_count = r_count;
    assign o_result_valid   = r_rv;
endmodule

// ===== hw/rtl/ckhs_ctrl.sv =====
module ckhs_ctrl #(
    parameter int MAX_PROBES = ckhs_pkg::MAX_PROBES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ckhs_pkg::t_sts i_sts,
    output ckhs_pkg::t_ctl o_ctl,
    output logic           o_busy
);
    localparam int PC_W = $clog2(MAX_PROBES + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MSTART, S_MRUN, S_MDONE, S_HOME, S_READ, S_CHECK, S_EMIT
    } t_state;

    t_state              r_state;
    ckhs_pkg::t_mul_sel  r_sel;
    logic [PC_W-1:0]     r_probes;
    logic                r_fnd, r_add, r_ful;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_sel    <= ckhs_pkg::MUL_K1;
            r_probes <= '0;
            r_fnd    <= 1'b0;
            r_add    <= 1'b0;
            r_ful    <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_MSTART;
                        r_sel   <= ckhs_pkg::MUL_K1;
                    end
                end
                S_MSTART: r_state <= S_MRUN;
                S_MRUN: begin
                    if (!i_sts.mul_busy) begin
                        r_state <= S_MDONE;
                    end
                end
                S_MDONE: begin
                    if (r_sel == ckhs_pkg::MUL_H2) begin
                        r_state <= S_HOME;
                    end else begin
                        r_sel   <= ckhs_pkg::t_mul_sel'(r_sel + 3'd1);
                        r_state <= S_MSTART;
                    end
                end
                S_HOME: begin
                    r_probes <= '0;
                    r_state  <= S_READ;
                end
                S_READ: begin
                    r_probes <= r_probes + 1'b1;
                    r_state  <= S_CHECK;
                end
                S_CHECK: begin
                    r_fnd <= i_sts.slot_valid && i_sts.key_match;
                    r_add <= !i_sts.slot_valid && i_sts.op_insert;
                    r_ful <= i_sts.slot_valid && !i_sts.key_match
                             && (r_probes == PC_W'(MAX_PROBES)) && i_sts.op_insert;
                    priority if (!i_sts.slot_valid || i_sts.key_match) begin
                        r_state <= S_EMIT;
                    end else if (r_probes == PC_W'(MAX_PROBES)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_EMIT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_ctl                = '0;
        o_ctl.mul_sel        = r_sel;
        o_ctl.clr            = (r_state == S_CLEAR);
        o_ctl.load           = (r_state == S_IDLE) && i_start;
        o_ctl.mul_start      = (r_state == S_MSTART);
        o_ctl.mul_step       = (r_state == S_MRUN) && i_sts.mul_busy;
        o_ctl.mul_done_apply = (r_state == S_MDONE);
        o_ctl.slot_init      = (r_state == S_HOME);
        o_ctl.rd_issue       = (r_state == S_READ);
        o_ctl.slot_next      = (r_state == S_CHECK) && i_sts.slot_valid
                               && !i_sts.key_match;
        o_ctl.wr_key         = (r_state == S_CHECK) && !i_sts.slot_valid
                               && i_sts.op_insert;
        o_ctl.emit           = (r_state == S_EMIT);
        o_ctl.res_found      = r_fnd;
        o_ctl.res_added      = r_add;
        o_ctl.res_full       = r_ful;
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// ===== hw/rtl/ckhs_checker.sv =====
module ckhs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_result_valid,
    input logic        o_found,
    input logic        o_added,
    input logic        o_table_full,
    input logic [12:0] o_distinct_count
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted item did not raise busy");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $onehot0({o_found, o_added, o_table_full}))
        else $error("result flags overlap");
    a_res_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy) else $error("result while still busy");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_added |-> $stable(o_distinct_count))
        else $error("count moved without an add");
endmodule

bind canonical_kmer_hash_set_top ckhs_checker u_ckhs_checker (.*);
